// File: rtl/core/uidtw_pkg.sv
`timescale 1ns / 1ps

package uidtw_pkg;

   localparam int unsigned TABLE_ENTRIES_DEFAULT = 64;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_FLUSH = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   localparam logic [1:0] MODE_REUID  = 2'd0;
   localparam logic [1:0] MODE_UID    = 2'd1;
   localparam logic [1:0] MODE_RESUID = 2'd2;
   localparam logic [1:0] MODE_FSUID  = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  mode;
      logic [31:0] pair_parent;
      logic [31:0] pair_child;
      logic [31:0] old_ruid;
      logic [31:0] old_euid;
      logic [31:0] old_suid;
      logic [31:0] old_fsuid;
      logic [31:0] new_ruid;
      logic [31:0] new_euid;
      logic [31:0] new_suid;
      logic [31:0] new_fsuid;
   } req_type;

   typedef struct packed {
      logic        allowed;
      logic        table_full;
      logic [31:0] denied_from;
      logic [31:0] denied_to;
   } rsp_type;

endpackage

// File: rtl/core/uid_transition_whitelist_checker.sv
`timescale 1ns / 1ps
// Adds, and checks whose first rule fails, scan the filled part of the table one entry a
// cycle through a single read port and one shared compare unit, then resolve and load
// rsp_valid; other items go straight to the resolve state. req_stall is high until the
// result is loaded; a stalled result holds the next item in its resolve cycle.
// Reset (synchronous, active high) clears the state, the fill count, disabled_ff,
// rsp_valid and the read-valid flag only.
module uid_transition_whitelist_checker
   import uidtw_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SCAN    = 3'b010,
      ST_RESOLVE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic        disabled_ff;
   logic [1:0]  cmd_ff;
   logic [31:0] key_parent_ff, key_from_ff, key_to_ff;
   logic        live_ff;
   logic        hit_parent_ff, hit_parent_in;
   logic        hit_pair_ff, hit_pair_in;
   logic        rd_vld_ff;
   logic [31:0] rd_parent_ff, rd_child_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0] mem_parent_ff [TABLE_ENTRIES];
   logic [31:0] mem_child_ff  [TABLE_ENTRIES];

   logic        accept, out_free, issuing, wr_en;
   logic        rule_fail;
   logic [31:0] rule_from, rule_to;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issuing   = (state_ff == ST_SCAN) && (addr_ff != count_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // first rule of the mode that fails, with its pair
   always_comb begin
      rule_fail = 1'b0;
      rule_from = '0;
      rule_to   = '0;
      unique case (req_data.mode)
         MODE_REUID: begin
            if (req_data.new_ruid != req_data.old_ruid
                  && req_data.new_ruid != req_data.old_euid) begin
               rule_fail = 1'b1;
               rule_from = req_data.old_ruid;
               rule_to   = req_data.new_ruid;
            end else if (req_data.new_euid != req_data.old_ruid
                  && req_data.new_euid != req_data.old_euid
                  && req_data.new_euid != req_data.old_suid) begin
               rule_fail = 1'b1;
               rule_from = req_data.old_euid;
               rule_to   = req_data.new_euid;
            end
         end
         MODE_UID: begin
            if (req_data.new_ruid != req_data.old_ruid) begin
               rule_fail = 1'b1;
               rule_from = req_data.old_ruid;
               rule_to   = req_data.new_ruid;
            end else if (req_data.new_suid != req_data.old_suid) begin
               rule_fail = 1'b1;
               rule_from = req_data.old_suid;
               rule_to   = req_data.new_suid;
            end
         end
         MODE_RESUID: begin
            if (req_data.new_ruid != req_data.old_ruid
                  && req_data.new_ruid != req_data.old_euid
                  && req_data.new_ruid != req_data.old_suid) begin
               rule_fail = 1'b1;
               rule_from = req_data.old_ruid;
               rule_to   = req_data.new_ruid;
            end else if (req_data.new_euid != req_data.old_ruid
                  && req_data.new_euid != req_data.old_euid
                  && req_data.new_euid != req_data.old_suid) begin
               rule_fail = 1'b1;
               rule_from = req_data.old_euid;
               rule_to   = req_data.new_euid;
            end else if (req_data.new_suid != req_data.old_ruid
                  && req_data.new_suid != req_data.old_euid
                  && req_data.new_suid != req_data.old_suid) begin
               rule_fail = 1'b1;
               rule_from = req_data.old_suid;
               rule_to   = req_data.new_suid;
            end
         end
         default: begin
            if (req_data.new_fsuid != req_data.old_ruid
                  && req_data.new_fsuid != req_data.old_euid
                  && req_data.new_fsuid != req_data.old_suid
                  && req_data.new_fsuid != req_data.old_fsuid) begin
               rule_fail = 1'b1;
               rule_from = req_data.old_fsuid;
               rule_to   = req_data.new_fsuid;
            end
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      hit_parent_in = hit_parent_ff;
      hit_pair_in   = hit_pair_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in       = '0;
               hit_parent_in = 1'b0;
               hit_pair_in   = 1'b0;
               if (req_data.cmd == CMD_ADD
                     || (req_data.cmd == CMD_CHECK && !disabled_ff && rule_fail)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESOLVE;
               end
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               addr_in = addr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_parent_ff == key_parent_ff) begin
                  hit_parent_in = 1'b1;
               end
               if (rd_parent_ff == key_from_ff && rd_child_ff == key_to_ff) begin
                  hit_pair_in = 1'b1;
               end
            end
            if (!issuing && !rd_vld_ff) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               case (cmd_ff)
                  CMD_ADD: begin
                     if (hit_pair_ff) begin
                        rsp_data_in.allowed = 1'b1;
                     end else if (count_ff == FULL_COUNT) begin
                        rsp_data_in.table_full = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                        rsp_data_in.allowed = 1'b1;
                     end
                  end
                  CMD_FLUSH: begin
                     count_in = '0;
                     rsp_data_in.allowed = 1'b1;
                  end
                  CMD_CHECK: begin
                     if (!live_ff || !hit_parent_ff || hit_pair_ff) begin
                        rsp_data_in.allowed = 1'b1;
                     end else begin
                        rsp_data_in.denied_from = key_from_ff;
                        rsp_data_in.denied_to   = key_to_ff;
                     end
                  end
                  default: begin
                     rsp_data_in.allowed = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         disabled_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_vld_ff     <= issuing;
         if (csr_wr_en) begin
            disabled_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      hit_parent_ff <= hit_parent_in;
      hit_pair_ff   <= hit_pair_in;
      rsp_data_ff   <= rsp_data_in;
      if (accept) begin
         cmd_ff        <= req_data.cmd;
         key_parent_ff <= req_data.old_ruid;
         live_ff       <= !disabled_ff && rule_fail;
         if (req_data.cmd == CMD_ADD) begin
            key_from_ff <= req_data.pair_parent;
            key_to_ff   <= req_data.pair_child;
         end else begin
            key_from_ff <= rule_from;
            key_to_ff   <= rule_to;
         end
      end
   end

   // table memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_parent_ff[count_ff[AW-1:0]] <= key_from_ff;
         mem_child_ff[count_ff[AW-1:0]]  <= key_to_ff;
      end
      if (issuing) begin
         rd_parent_ff <= mem_parent_ff[addr_ff[AW-1:0]];
         rd_child_ff  <= mem_child_ff[addr_ff[AW-1:0]];
      end
   end

endmodule

// File: tb/tb_uid_transition_whitelist_checker.sv
`timescale 1ns / 1ps

import uidtw_pkg::*;

class uid_verdict_scoreboard;
   logic [31:0] parent_uid [TABLE_ENTRIES_DEFAULT];
   logic [31:0] child_uid  [TABLE_ENTRIES_DEFAULT];
   bit          in_use     [TABLE_ENTRIES_DEFAULT];
   bit          policies_off;
   rsp_type     expected_verdicts [$];
   int          errors;

   function void set_policies(bit off);
      policies_off = off;
   endfunction

   function int outstanding();
      return expected_verdicts.size();
   endfunction

   function bit has_parent(logic [31:0] p);
      foreach (in_use[i]) if (in_use[i] && parent_uid[i] == p) return 1'b1;
      return 1'b0;
   endfunction

   function bit has_pair(logic [31:0] p, logic [31:0] c);
      foreach (in_use[i]) if (in_use[i] && parent_uid[i] == p && child_uid[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function bit among(logic [31:0] v, logic [31:0] a, logic [31:0] b, logic [31:0] c);
      return v == a || v == b || v == c;
   endfunction

   function rsp_type predict_verdict(req_type r);
      rsp_type     res;
      bit          hit;
      logic [31:0] rule_from;
      logic [31:0] rule_to;
      int          slot;
      res = '0;
      hit = 1'b0;
      rule_from = '0;
      rule_to = '0;
      slot = -1;
      case (r.cmd)
         CMD_ADD: begin
            if (has_pair(r.pair_parent, r.pair_child)) begin
               res.allowed = 1'b1;
            end else begin
               for (int i = 0; i < TABLE_ENTRIES_DEFAULT; i++) begin
                  if (!in_use[i]) begin
                     slot = i;
                     break;
                  end
               end
               if (slot < 0) begin
                  res.table_full = 1'b1;
               end else begin
                  parent_uid[slot] = r.pair_parent;
                  child_uid[slot] = r.pair_child;
                  in_use[slot] = 1'b1;
                  res.allowed = 1'b1;
               end
            end
         end
         CMD_FLUSH: begin
            foreach (in_use[i]) in_use[i] = 1'b0;
            res.allowed = 1'b1;
         end
         CMD_CHECK: begin
            res.allowed = 1'b1;
            if (!policies_off && has_parent(r.old_ruid)) begin
               case (r.mode)
                  MODE_REUID: begin
                     if (r.new_ruid != r.old_ruid && r.new_ruid != r.old_euid) begin
                        hit = 1'b1;
                        rule_from = r.old_ruid;
                        rule_to = r.new_ruid;
                     end else if (!among(r.new_euid, r.old_ruid, r.old_euid, r.old_suid)) begin
                        hit = 1'b1;
                        rule_from = r.old_euid;
                        rule_to = r.new_euid;
                     end
                  end
                  MODE_UID: begin
                     if (r.new_ruid != r.old_ruid) begin
                        hit = 1'b1;
                        rule_from = r.old_ruid;
                        rule_to = r.new_ruid;
                     end else if (r.new_suid != r.old_suid) begin
                        hit = 1'b1;
                        rule_from = r.old_suid;
                        rule_to = r.new_suid;
                     end
                  end
                  MODE_RESUID: begin
                     if (!among(r.new_ruid, r.old_ruid, r.old_euid, r.old_suid)) begin
                        hit = 1'b1;
                        rule_from = r.old_ruid;
                        rule_to = r.new_ruid;
                     end else if (!among(r.new_euid, r.old_ruid, r.old_euid, r.old_suid)) begin
                        hit = 1'b1;
                        rule_from = r.old_euid;
                        rule_to = r.new_euid;
                     end else if (!among(r.new_suid, r.old_ruid, r.old_euid, r.old_suid)) begin
                        hit = 1'b1;
                        rule_from = r.old_suid;
                        rule_to = r.new_suid;
                     end
                  end
                  default: begin
                     if (!among(r.new_fsuid, r.old_ruid, r.old_euid, r.old_suid)
                         && r.new_fsuid != r.old_fsuid) begin
                        hit = 1'b1;
                        rule_from = r.old_fsuid;
                        rule_to = r.new_fsuid;
                     end
                  end
               endcase
               if (hit && !has_pair(rule_from, rule_to)) begin
                  res.allowed = 1'b0;
                  res.denied_from = rule_from;
                  res.denied_to = rule_to;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function void note_request(req_type r);
      expected_verdicts.push_back(predict_verdict(r));
   endfunction

   task report(string what);
      errors++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   task check_response(rsp_type got);
      rsp_type want;
      if (expected_verdicts.size() == 0) begin
         report($sformatf("unexpected item %h", got));
      end else begin
         want = expected_verdicts.pop_front();
         if (got.allowed !== want.allowed)
            report($sformatf("allowed %b, want %b", got.allowed, want.allowed));
         if (got.table_full !== want.table_full)
            report($sformatf("table_full %b, want %b", got.table_full, want.table_full));
         if (got.denied_from !== want.denied_from)
            report($sformatf("denied_from %h, want %h", got.denied_from, want.denied_from));
         if (got.denied_to !== want.denied_to)
            report($sformatf("denied_to %h, want %h", got.denied_to, want.denied_to));
      end
   endtask
endclass

module tb_uid_transition_whitelist_checker;
   localparam int         HANG_LIMIT  = 3000;
   localparam int         LONG_HOLD   = 400;
   localparam int         PHASE_ITEMS = 360;
   localparam int         POOL_SIZE   = 8;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   localparam logic [31:0] U_ZERO = 32'h0000_0000;
   localparam logic [31:0] U_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] U_MID  = 32'h1234_5678;
   localparam logic [31:0] U_ODD  = 32'hA5A5_A5A5;
   localparam logic [31:0] U_EVEN = 32'h5A5A_5A5A;

   typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_PERIODIC} stall_style_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;

   uid_verdict_scoreboard verdicts;
   logic [31:0]           uid_pool [POOL_SIZE];
   bit                    offering = 1'b0;
   bit                    long_hold_due = 1'b0;
   int                    burst_left = 0;
   int                    sent = 0;
   int                    idle_cycles = 0;

   uid_transition_whitelist_checker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) verdicts.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) verdicts.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : receiver
      stall_style_type style;
      int              seg_left;
      int              hold_left;
      style = STALL_NONE;
      seg_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               style = stall_style_type'($urandom_range(0, 3));
               seg_left = $urandom_range(16, 160);
            end
            seg_left--;
            case (style)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_COIN:  rsp_stall <= 1'($urandom_range(0, 1));
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= (seg_left % 6 < 2);
            endcase
         end
      end
   end

   function automatic req_type noise_item();
      req_type r;
      r.cmd         = 2'($urandom_range(0, 3));
      r.mode        = 2'($urandom_range(0, 3));
      r.pair_parent = $urandom;
      r.pair_child  = $urandom;
      r.old_ruid    = $urandom;
      r.old_euid    = $urandom;
      r.old_suid    = $urandom;
      r.old_fsuid   = $urandom;
      r.new_ruid    = $urandom;
      r.new_euid    = $urandom;
      r.new_suid    = $urandom;
      r.new_fsuid   = $urandom;
      return r;
   endfunction

   function automatic req_type cmd_item(logic [1:0] cmd);
      req_type r;
      r = noise_item();
      r.cmd = cmd;
      return r;
   endfunction

   function automatic req_type add_item(logic [31:0] p, logic [31:0] c);
      req_type r;
      r = cmd_item(CMD_ADD);
      r.pair_parent = p;
      r.pair_child = c;
      return r;
   endfunction

   function automatic req_type check_item(logic [1:0] mode,
         logic [31:0] o_r, logic [31:0] o_e, logic [31:0] o_s, logic [31:0] o_f,
         logic [31:0] n_r, logic [31:0] n_e, logic [31:0] n_s, logic [31:0] n_f);
      req_type r;
      r = cmd_item(CMD_CHECK);
      r.mode = mode;
      r.old_ruid = o_r;
      r.old_euid = o_e;
      r.old_suid = o_s;
      r.old_fsuid = o_f;
      r.new_ruid = n_r;
      r.new_euid = n_e;
      r.new_suid = n_s;
      r.new_fsuid = n_f;
      return r;
   endfunction

   function automatic logic [31:0] pick_uid();
      return ($urandom_range(0, 99) < 85) ? uid_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
   endfunction

   function automatic req_type random_check();
      logic [31:0] o [4];
      logic [31:0] n [4];
      foreach (o[i]) o[i] = pick_uid();
      foreach (n[i]) n[i] = ($urandom_range(0, 99) < 45) ? o[$urandom_range(0, 3)] : pick_uid();
      return check_item(2'($urandom_range(0, 3)), o[0], o[1], o[2], o[3],
                        n[0], n[1], n[2], n[3]);
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data <= item;
      offering = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
      end
   endtask

   task automatic send_step(input req_type item);
      if ($urandom_range(0, 99) < 8) send_item(noise_item());
      send_item(item);
   endtask

   task automatic drain();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
      while (verdicts.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_policies(input bit off);
      csr_wr_en <= 1'b1;
      csr_wr_data <= off;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      verdicts.set_policies(off);
   endtask

   task automatic run_directed();
      send_item(check_item(MODE_REUID, U_ZERO, U_ZERO, U_ZERO, U_ZERO,
                           U_ONES, U_ZERO, U_ZERO, U_ZERO));
      send_item(cmd_item(CMD_UNKNOWN));
      send_item(add_item(U_ZERO, U_ONES));
      send_item(add_item(U_ZERO, U_ONES));
      send_item(add_item(U_ONES, U_ZERO));
      send_item(check_item(MODE_REUID, U_ZERO, U_MID, U_MID, U_MID, U_ONES, U_MID, U_MID, U_MID));
      send_item(check_item(MODE_REUID, U_ZERO, U_MID, U_MID, U_MID, U_MID, U_ONES, U_MID, U_MID));
      send_item(check_item(MODE_REUID, U_ZERO, U_MID, U_MID, U_MID, U_ODD, U_MID, U_MID, U_MID));
      send_item(check_item(MODE_UID, U_ZERO, U_MID, U_MID, U_MID, U_ZERO, U_ONES, U_ONES, U_ONES));
      send_item(check_item(MODE_UID, U_ZERO, U_MID, U_MID, U_MID, U_ONES, U_MID, U_MID, U_MID));
      send_item(check_item(MODE_RESUID, U_ZERO, U_MID, U_ONES, U_ZERO,
                           U_ONES, U_ZERO, U_MID, U_EVEN));
      send_item(check_item(MODE_RESUID, U_ZERO, U_MID, U_ONES, U_ZERO,
                           U_ONES, U_ZERO, U_EVEN, U_ZERO));
      send_item(check_item(MODE_RESUID, U_ZERO, U_MID, U_ONES, U_ZERO,
                           U_ODD, U_ZERO, U_ZERO, U_ZERO));
      send_item(check_item(MODE_FSUID, U_ZERO, U_MID, U_MID, U_ONES,
                           U_ZERO, U_ZERO, U_ZERO, U_EVEN));
      send_item(check_item(MODE_FSUID, U_ONES, U_MID, U_MID, U_ONES,
                           U_ZERO, U_ZERO, U_ZERO, U_ZERO));
      send_item(check_item(MODE_FSUID, U_ZERO, U_MID, U_MID, U_ONES,
                           U_ZERO, U_ZERO, U_ZERO, U_MID));
      send_item(check_item(MODE_REUID, U_MID, U_ZERO, U_ZERO, U_ZERO,
                           U_ODD, U_ODD, U_ODD, U_ODD));
      send_item(cmd_item(CMD_FLUSH));
      send_item(check_item(MODE_REUID, U_ZERO, U_MID, U_MID, U_MID, U_MID, U_ONES, U_MID, U_MID));
      send_item(cmd_item(CMD_UNKNOWN));
   endtask

   task automatic run_episode();
      int k2;
      if ($urandom_range(0, 3) == 0) begin
         // pool pairs exactly fill the table, then overflow it
         send_step(cmd_item(CMD_FLUSH));
         for (int k = 0; k < POOL_SIZE * POOL_SIZE; k++) begin
            send_step(add_item(uid_pool[k / POOL_SIZE], uid_pool[k % POOL_SIZE]));
            if ($urandom_range(0, 3) == 0) send_step(random_check());
            if ($urandom_range(0, 9) == 0) begin
               k2 = $urandom_range(0, k);
               send_step(add_item(uid_pool[k2 / POOL_SIZE], uid_pool[k2 % POOL_SIZE]));
            end
         end
         repeat (2) send_step(add_item($urandom, $urandom));
         send_step(add_item(uid_pool[$urandom_range(0, POOL_SIZE - 1)],
                            uid_pool[$urandom_range(0, POOL_SIZE - 1)]));
         repeat ($urandom_range(5, 15)) send_step(random_check());
      end else begin
         if ($urandom_range(0, 9) < 7) send_step(cmd_item(CMD_FLUSH));
         repeat ($urandom_range(1, 12))
            send_step(add_item(uid_pool[$urandom_range(0, POOL_SIZE - 1)],
                               uid_pool[$urandom_range(0, POOL_SIZE - 1)]));
         repeat ($urandom_range(10, 30)) send_step(random_check());
      end
   endtask

   initial begin : stimulus
      bit dup;
      int phase_start;
      verdicts = new();
      uid_pool[0] = U_ZERO;
      uid_pool[1] = U_ONES;
      for (int i = 2; i < POOL_SIZE; i++) begin
         do begin
            uid_pool[i] = $urandom;
            dup = 1'b0;
            for (int j = 0; j < i; j++) if (uid_pool[j] == uid_pool[i]) dup = 1'b1;
         end while (dup);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         write_policies(ph % 2);
         if (ph == 0) begin
            run_directed();
            long_hold_due = 1'b1;
         end
         phase_start = sent;
         while (sent - phase_start < PHASE_ITEMS) run_episode();
      end
      drain();
      repeat (20) @(posedge clock);
      if (verdicts.outstanding() != 0) verdicts.report("results still outstanding at the end");
      if (verdicts.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// File: uid_transition_whitelist_checker.f
rtl/core/uidtw_pkg.sv
rtl/core/uid_transition_whitelist_checker.sv
tb/tb_uid_transition_whitelist_checker.sv
